>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the ALU flags and stack unit.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SMALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define SMALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/smalu_pkg.sv
// Package for the ALU flags and stack unit: operation codes, flag positions,
// request and result records. No dependencies.
`default_nettype none

package smalu_pkg;

    localparam logic [2:0] OP_INC8   = 3'd0;
    localparam logic [2:0] OP_DEC8   = 3'd1;
    localparam logic [2:0] OP_RL     = 3'd2;
    localparam logic [2:0] OP_BIT    = 3'd3;
    localparam logic [2:0] OP_PUSH   = 3'd4;
    localparam logic [2:0] OP_POP    = 3'd5;
    localparam logic [2:0] OP_LDSP   = 3'd6;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [3:0] NIBBLE_ALL = 4'hF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  operand_byte;
        logic [2:0]  bit_index;
        logic [15:0] operand_word;
        logic [15:0] stack_word;
    } req_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [3:0]  flag_nibble;
        logic        mem_write;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic        last;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/smalu_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
`default_nettype none

interface smalu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  operand_byte;
    logic [2:0]  bit_index;
    logic [15:0] operand_word;
    logic [15:0] stack_word;

    modport source (output valid, req_type, operand_byte, bit_index, operand_word,
                    stack_word, input ready);
    modport sink (input valid, req_type, operand_byte, bit_index, operand_word,
                  stack_word, output ready);
endinterface

interface smalu_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic [3:0]  flag_nibble;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic        last;

    modport source (output valid, result_byte, result_word, flag_nibble, mem_write,
                    mem_addr, mem_data, last, input ready);
    modport sink (input valid, result_byte, result_word, flag_nibble, mem_write,
                  mem_addr, mem_data, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smalu_exec.sv
// Execute logic: one result and the next flags and stack pointer for a request.
// Depends on smalu_pkg.
`default_nettype none

module smalu_exec
    import smalu_pkg::*;
(
    input  var req_t        req,
    input  var logic        second,
    input  var logic [3:0]  flags,
    input  var logic [15:0] sp,
    output var rsp_t        rsp,
    output var logic [3:0]  flags_next,
    output var logic [15:0] sp_next
);

    logic [7:0] r;
    logic [3:0] f;

    always_comb
    begin
        rsp        = '0;
        rsp.last   = 1'b1;
        r          = '0;
        f          = flags;
        sp_next    = sp;
        case (req.req_type)
            OP_INC8:
            begin
                r         = req.operand_byte + 8'd1;
                f[FLAG_Z] = (r == 8'd0);
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = (req.operand_byte[3:0] == NIBBLE_ALL);
                rsp.result_byte = r;
            end
            OP_DEC8:
            begin
                r         = req.operand_byte - 8'd1;
                f[FLAG_Z] = (r == 8'd0);
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (req.operand_byte[3:0] == 4'd0);
                rsp.result_byte = r;
            end
            OP_RL:
            begin
                r         = {req.operand_byte[6:0], flags[FLAG_C]};
                f[FLAG_Z] = (r == 8'd0);
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = 1'b0;
                f[FLAG_C] = req.operand_byte[7];
                rsp.result_byte = r;
            end
            OP_BIT:
            begin
                f[FLAG_Z] = ~req.operand_byte[req.bit_index];
                f[FLAG_N] = 1'b0;
                f[FLAG_H] = 1'b1;
            end
            OP_PUSH:
            begin
                rsp.mem_write = 1'b1;
                // high byte first; SP moves only with the second write
                if (!second)
                begin
                    rsp.mem_addr = sp - 16'd1;
                    rsp.mem_data = req.operand_word[15:8];
                    rsp.last     = 1'b0;
                end
                else
                begin
                    rsp.mem_addr = sp - 16'd2;
                    rsp.mem_data = req.operand_word[7:0];
                    sp_next      = sp - 16'd2;
                end
            end
            OP_POP:
            begin
                rsp.result_word = req.stack_word;
                rsp.mem_addr    = sp;
                sp_next         = sp + 16'd2;
            end
            OP_LDSP:
            begin
                sp_next = req.operand_word;
            end
            default:
            begin
                f = flags;
            end
        endcase
        rsp.flag_nibble = f;
        flags_next      = f;
    end

endmodule

`default_nettype wire

>>> rtl/core/sm83_alu_flags_and_stack_unit_top.sv
// A request accepted into the input register goes through the execute logic
// into the output register, which gives its first result; a full output
// register that is not taken stalls it. Throughput: one request per cycle
// while the output is not stalled; push holds the input register for its second
// memory write. The output register decouples the sides. Reset (rst_n,
// asynchronous, active low) clears flags, stack pointer and all valid state.
`default_nettype none
`include "assert_macros.svh"

// Top level: input register, execute logic, result register, flag and SP state.
// Depends on smalu_pkg, smalu_if, smalu_exec and assert_macros.svh.
module sm83_alu_flags_and_stack_unit_top
    import smalu_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    smalu_req_if.sink    req,
    smalu_rsp_if.source  rsp
);

    logic        s1_valid_reg, s1_valid_next;
    req_t        s1_req_reg;
    logic        phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_rsp_reg;
    logic [3:0]  flags_reg;
    logic [15:0] sp_reg;

    rsp_t        exec_rsp;
    logic [3:0]  exec_flags;
    logic [15:0] exec_sp;
    logic        s1_emit;
    logic        s1_done;
    logic        in_fire;

    smalu_exec u_exec (
        .req        (s1_req_reg),
        .second     (phase_reg),
        .flags      (flags_reg),
        .sp         (sp_reg),
        .rsp        (exec_rsp),
        .flags_next (exec_flags),
        .sp_next    (exec_sp)
    );

    assign s1_emit   = s1_valid_reg & (~out_valid_reg | rsp.ready);
    assign s1_done   = s1_emit & exec_rsp.last;
    assign req.ready = ~s1_valid_reg | s1_done;
    assign in_fire   = req.valid & req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;

        phase_next = phase_reg;
        if (s1_done)
            phase_next = 1'b0;
        else if (s1_emit)
            phase_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (s1_emit)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            sp_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (s1_emit)
            begin
                flags_reg <= exec_flags;
                sp_reg    <= exec_sp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg.req_type     <= req.req_type;
            s1_req_reg.operand_byte <= req.operand_byte;
            s1_req_reg.bit_index    <= req.bit_index;
            s1_req_reg.operand_word <= req.operand_word;
            s1_req_reg.stack_word   <= req.stack_word;
        end
        if (s1_emit)
            out_rsp_reg <= exec_rsp;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_byte = out_rsp_reg.result_byte;
    assign rsp.result_word = out_rsp_reg.result_word;
    assign rsp.flag_nibble = out_rsp_reg.flag_nibble;
    assign rsp.mem_write   = out_rsp_reg.mem_write;
    assign rsp.mem_addr    = out_rsp_reg.mem_addr;
    assign rsp.mem_data    = out_rsp_reg.mem_data;
    assign rsp.last        = out_rsp_reg.last;

    `SMALU_ASSERT_NOW(a_phase_only_push, phase_reg,
        s1_valid_reg && (s1_req_reg.req_type == OP_PUSH), "second phase without a push")
    `SMALU_ASSERT_NEXT(a_push_holds, s1_emit && !exec_rsp.last,
        phase_reg && s1_valid_reg && (s1_req_reg.req_type == OP_PUSH),
        "push left before its second write")
    `SMALU_ASSERT_NOW(a_last_write_second, s1_emit && exec_rsp.mem_write && exec_rsp.last,
        phase_reg, "final push write issued in first phase")
    `SMALU_ASSERT_NEXT(a_push_sp_step, s1_emit && phase_reg,
        sp_reg == ($past(sp_reg) - 16'd2), "push did not lower SP by two")

endmodule

`default_nettype wire
